@@ rtl/cr_eval_pkg.sv @@
// Package for the Catmull-Rom cubic evaluator.
// Holds the command codes shared by the evaluator's RTL; depends on nothing.
package cr_eval_pkg;

    typedef enum logic {
        CMD_POSITION = 1'b0,
        CMD_TANGENT  = 1'b1
    } cmd_t;

endpackage

@@ rtl/catmull_rom_cubic_eval_unit.sv @@
// Uniform Catmull-Rom cubic segment evaluator, one coordinate axis per transfer.
// Depends on cr_eval_pkg for the command codes.

// The unit takes one transfer per clock while the output side does not stall
// and returns one result transfer for each. Each input transfer carries four
// signed fixed-point control coordinates, the curve parameter t in
// unsigned Q1.T_FRAC_BITS (values above 1.0 act as 1.0) and a
// command in tuser: position or tangent. The result keeps the coordinate
// format, is rounded half toward plus infinity and saturates at the signed
// COORD_WIDTH range. Rate is set by the eight-stage datapath (t squared, t
// cubed, weights, split partial products, product merge, two adder levels,
// saturation); each stage holds only while the stage after it is full and
// stalled, so bubbles are absorbed and a stalled output does not block the
// input side until the pipeline is full.
module catmull_rom_cubic_eval_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16,
    localparam int S_DATA_W = ((4 * COORD_WIDTH + T_FRAC_BITS + 1 + 7) / 8) * 8,
    localparam int M_DATA_W = ((COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // point_a, point_b, point_c, point_d, param_t, zero fill
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // command
    input  logic [0:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // value, zero fill
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    import cr_eval_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int F     = T_FRAC_BITS;
    localparam int T_W   = F + 1;
    localparam int SQ_W  = 2 * F + 2;
    localparam int WI    = F + 6;
    localparam int WW    = F + 4;
    localparam int LO_W  = CW / 2;
    localparam int HI_W  = CW - LO_W;
    localparam int PL_W  = LO_W + 1 + WW;
    localparam int PH_W  = HI_W + WW;
    localparam int PR_W  = CW + WW;
    localparam int PS_W  = PR_W + 1;
    localparam int ACC_W = PR_W + 2;
    localparam int RD_W  = ACC_W - F - 1;
    localparam int NST   = 7;

    localparam logic [T_W-1:0]          T_ONE   = {1'b1, {F{1'b0}}};
    localparam logic [SQ_W-1:0]         HALF_SQ = SQ_W'(1) << (F - 1);
    localparam logic signed [WI-1:0]    S_WI    = WI'(1) << F;
    localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) << F;

    logic ld [1:NST+1];
    logic vld_reg [1:NST];
    logic m_valid_reg;

    // Stage 1: clamp t and square it.
    cmd_t                   p1_cmd_reg;
    logic [CW-1:0]          p1_pts_reg [4];
    logic [T_W-1:0]         p1_tc_reg;
    logic [T_W-1:0]         p1_u2_reg;
    logic [T_W-1:0]         t_in;
    logic [T_W-1:0]         tc_next;
    logic [SQ_W-1:0]        sq_sum;

    // Stage 2: cube.
    cmd_t                   p2_cmd_reg;
    logic [CW-1:0]          p2_pts_reg [4];
    logic [T_W-1:0]         p2_tc_reg;
    logic [T_W-1:0]         p2_u2_reg;
    logic [T_W-1:0]         p2_u3_reg;
    logic [SQ_W-1:0]        cube_sum;

    // Stage 3: doubled weights.
    logic [CW-1:0]          p3_pts_reg [4];
    logic signed [WW-1:0]   p3_w_reg [4];
    logic signed [WI-1:0]   e2, e3, et;
    logic signed [WI-1:0]   wf [4];

    // Stage 4: partial products.
    logic signed [PL_W-1:0] p4_lo_reg [4];
    logic signed [PH_W-1:0] p4_hi_reg [4];

    // Stage 5: full products.
    logic signed [PR_W-1:0] p5_prod_reg [4];

    // Stage 6: pair sums.
    logic signed [PS_W-1:0] p6_s01_reg;
    logic signed [PS_W-1:0] p6_s23_reg;

    // Stage 7: total, rounding and scaling.
    logic signed [ACC_W-1:0] total;
    logic signed [RD_W-1:0]  p7_rnd_reg;

    // Stage 8: saturation into the output register.
    logic [CW-1:0]           value_next;
    logic [CW-1:0]           m_data_reg;
    logic [RD_W-CW:0]        top_bits;

    always_comb begin
        ld[NST+1] = !m_valid_reg || m_axis_tready;
        for (int k = NST; k >= 1; k--) begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end

    assign s_axis_tready = ld[1];
    assign m_axis_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= NST; k++) begin
                vld_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            if (ld[1]) begin
                vld_reg[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (ld[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (ld[NST+1]) begin
                m_valid_reg <= vld_reg[NST];
            end
        end
    end

    always_comb begin
        t_in    = s_axis_tdata[4*CW +: T_W];
        tc_next = (t_in > T_ONE) ? T_ONE : t_in;
        sq_sum  = SQ_W'(tc_next) * SQ_W'(tc_next) + HALF_SQ;
    end

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            p1_cmd_reg <= cmd_t'(s_axis_tuser[0]);
            for (int i = 0; i < 4; i++) begin
                p1_pts_reg[i] <= s_axis_tdata[i*CW +: CW];
            end
            p1_tc_reg <= tc_next;
            p1_u2_reg <= sq_sum[2*F:F];
        end
    end

    assign cube_sum = SQ_W'(p1_u2_reg) * SQ_W'(p1_tc_reg) + HALF_SQ;

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            p2_cmd_reg <= p1_cmd_reg;
            p2_pts_reg <= p1_pts_reg;
            p2_tc_reg  <= p1_tc_reg;
            p2_u2_reg  <= p1_u2_reg;
            p2_u3_reg  <= cube_sum[2*F:F];
        end
    end

    always_comb begin
        e2 = $signed({{(WI-T_W){1'b0}}, p2_u2_reg});
        e3 = $signed({{(WI-T_W){1'b0}}, p2_u3_reg});
        et = $signed({{(WI-T_W){1'b0}}, p2_tc_reg});
        if (p2_cmd_reg == CMD_TANGENT) begin
            wf[0] = -((e2 <<< 1) + e2) + (et <<< 2) - S_WI;
            wf[1] = (e2 <<< 3) + e2 - ((et <<< 3) + (et <<< 1));
            wf[2] = -((e2 <<< 3) + e2) + (et <<< 3) + S_WI;
            wf[3] = (e2 <<< 1) + e2 - (et <<< 1);
        end else begin
            wf[0] = -e3 + (e2 <<< 1) - et;
            wf[1] = (e3 <<< 1) + e3 - ((e2 <<< 2) + e2) + (S_WI <<< 1);
            wf[2] = -((e3 <<< 1) + e3) + (e2 <<< 2) + et;
            wf[3] = e3 - e2;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            p3_pts_reg <= p2_pts_reg;
            for (int i = 0; i < 4; i++) begin
                p3_w_reg[i] <= wf[i][WW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[4]) begin
            for (int i = 0; i < 4; i++) begin
                p4_lo_reg[i] <= $signed({{(PL_W-LO_W){1'b0}}, p3_pts_reg[i][LO_W-1:0]})
                              * $signed({{(PL_W-WW){p3_w_reg[i][WW-1]}}, p3_w_reg[i]});
                p4_hi_reg[i] <= $signed({{(PH_W-HI_W){p3_pts_reg[i][CW-1]}},
                                         p3_pts_reg[i][CW-1:LO_W]})
                              * $signed({{(PH_W-WW){p3_w_reg[i][WW-1]}}, p3_w_reg[i]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[5]) begin
            for (int i = 0; i < 4; i++) begin
                p5_prod_reg[i] <= $signed({p4_hi_reg[i], {LO_W{1'b0}}})
                                + $signed({{(PR_W-PL_W){p4_lo_reg[i][PL_W-1]}}, p4_lo_reg[i]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[6]) begin
            p6_s01_reg <= $signed({p5_prod_reg[0][PR_W-1], p5_prod_reg[0]})
                        + $signed({p5_prod_reg[1][PR_W-1], p5_prod_reg[1]});
            p6_s23_reg <= $signed({p5_prod_reg[2][PR_W-1], p5_prod_reg[2]})
                        + $signed({p5_prod_reg[3][PR_W-1], p5_prod_reg[3]});
        end
    end

    assign total = $signed({p6_s01_reg[PS_W-1], p6_s01_reg})
                 + $signed({p6_s23_reg[PS_W-1], p6_s23_reg}) + ROUND_C;

    always_ff @(posedge aclk) begin
        if (ld[7]) begin
            p7_rnd_reg <= total[ACC_W-1:F+1];
        end
    end

    always_comb begin
        top_bits = p7_rnd_reg[RD_W-1:CW-1];
        if ((&top_bits) || !(|top_bits)) begin
            value_next = p7_rnd_reg[CW-1:0];
        end else if (p7_rnd_reg[RD_W-1]) begin
            value_next = {1'b1, {(CW-1){1'b0}}};
        end else begin
            value_next = {1'b0, {(CW-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[NST+1]) begin
            m_data_reg <= value_next;
        end
    end

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[CW-1:0] = m_data_reg;
    end

`ifndef SYNTHESIS
    a_powers_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[2] |-> (p2_u3_reg <= p2_u2_reg) && (p2_u2_reg <= p2_tc_reg)
                       && (p2_tc_reg <= T_ONE))
        else $error("t powers out of order in the cube stage");

    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[1] |-> s_axis_tready)
        else $error("input not ready although the first stage is empty");

    a_last_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[NST] && m_valid_reg && !m_axis_tready |=> vld_reg[NST] && $stable(p7_rnd_reg))
        else $error("last pipeline stage changed during an output stall");
`endif

endmodule
